// File: rtl/attitude_pid_with_quad_mixer_assert.svh
`ifndef ATTITUDE_PID_WITH_QUAD_MIXER_ASSERT_SVH
`define ATTITUDE_PID_WITH_QUAD_MIXER_ASSERT_SVH

// clocked check, masked during reset
`define APQM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// value stays within lo..hi whenever cond holds
`define APQM_ASSERT_RANGE(label, cond, sig, lo, hi, msg) \
	`APQM_ASSERT(label, (cond) |-> ((sig) >= (lo) && (sig) <= (hi)), msg)

`endif

// File: rtl/apqm_pkg.sv
package apqm_pkg;

	localparam int ANGLE_FRAC_BITS = 7;
	localparam int GAIN_FRAC_BITS  = 8;
	localparam int FRAC_W          = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;

	localparam int NUM_AXES   = 3;
	localparam int AXIS_ROLL  = 0;
	localparam int AXIS_PITCH = 1;
	localparam int AXIS_YAW   = 2;

	localparam int THR_W   = 11;
	localparam int ANGLE_W = 16;
	localparam int GAIN_W  = 16;
	localparam int WIN_W   = 15;
	localparam int LIM_W   = 10;
	localparam int CORR_W  = 11;
	localparam int MOTOR_W = 11;

	localparam int ERR_W  = ANGLE_W + 1;
	localparam int PAIR_W = ERR_W + 1;
	localparam int PROD_W = GAIN_W + PAIR_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int SUM_W  = ACC_W + 1;
	localparam int INT_W  = LIM_W + FRAC_W + 1;
	localparam int MIX_W  = THR_W + 3;

	localparam int MOTOR_MIN = 1000;
	localparam int MOTOR_MAX = 1900;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(768);
	localparam logic [LIM_W-1:0] LIMIT_RESET  = LIM_W'(300);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P_TILT,
		REG_GAIN_I_TILT,
		REG_GAIN_D_TILT,
		REG_GAIN_P_YAW,
		REG_GAIN_I_YAW,
		REG_GAIN_D_YAW,
		REG_INTEGRATE_WINDOW,
		REG_CORRECTION_LIMIT
	} cfg_reg_t;

endpackage

// File: rtl/attitude_pid_with_quad_mixer.sv
// channel  direction  handshake            payload
// in       to block   in_valid / in_ready  throttle, angles, yaw rate, three targets
// out      from block out_valid / out_ready four motor commands, three corrections
// cfg      to block   cfg_we               cfg_index, cfg_data
//
// One transfer per cycle sustained while out_ready holds; data passes stage registers 1 to 5, then the result register.
// The integral recurrence closes in one stage: old integral plus halved product (only inside the window), clamp.
// Reset clears gains to zero, window to 768, limit to 300, integrals and errors to zero.
// Each stage holds while the next is full and stalled; bubbles collapse.
module attitude_pid_with_quad_mixer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [apqm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [apqm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [apqm_pkg::THR_W-1:0]           throttle,
	input  logic signed [apqm_pkg::ANGLE_W-1:0]  roll_angle,
	input  logic signed [apqm_pkg::ANGLE_W-1:0]  pitch_angle,
	input  logic signed [apqm_pkg::ANGLE_W-1:0]  yaw_rate,
	input  logic signed [apqm_pkg::ANGLE_W-1:0]  roll_target,
	input  logic signed [apqm_pkg::ANGLE_W-1:0]  pitch_target,
	input  logic signed [apqm_pkg::ANGLE_W-1:0]  yaw_target,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [apqm_pkg::MOTOR_W-1:0]         motor_front_a,
	output logic [apqm_pkg::MOTOR_W-1:0]         motor_front_b,
	output logic [apqm_pkg::MOTOR_W-1:0]         motor_rear_a,
	output logic [apqm_pkg::MOTOR_W-1:0]         motor_rear_b,
	output logic signed [apqm_pkg::CORR_W-1:0]   roll_correction,
	output logic signed [apqm_pkg::CORR_W-1:0]   pitch_correction,
	output logic signed [apqm_pkg::CORR_W-1:0]   yaw_correction
);
	import apqm_pkg::*;

	function automatic logic [MOTOR_W-1:0] clamp_motor(input logic signed [MIX_W-1:0] v);
		logic [MOTOR_W-1:0] r;
		if (v < MOTOR_MIN) begin
			r = MOTOR_W'(MOTOR_MIN);
		end else if (v > MOTOR_MAX) begin
			r = MOTOR_W'(MOTOR_MAX);
		end else begin
			r = v[MOTOR_W-1:0];
		end
		return r;
	endfunction

	logic [GAIN_W-1:0] kp_tilt_q, ki_tilt_q, kd_tilt_q;
	logic [GAIN_W-1:0] kp_yaw_q, ki_yaw_q, kd_yaw_q;
	logic [WIN_W-1:0]  window_q;
	logic [LIM_W-1:0]  limit_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_out;

	logic signed [ERR_W-1:0] prev_q  [NUM_AXES];
	logic signed [INT_W-1:0] integ_q [NUM_AXES];

	logic [THR_W-1:0]          thr_s1, thr_s2, thr_s3, thr_s4, thr_s5;
	logic signed [ANGLE_W-1:0] meas_s1 [NUM_AXES];
	logic signed [ANGLE_W-1:0] tgt_s1  [NUM_AXES];
	logic signed [ERR_W-1:0]   err_s2  [NUM_AXES];
	logic signed [ERR_W-1:0]   prev_s2 [NUM_AXES];
	logic                      win_s2  [NUM_AXES];
	logic signed [PROD_W-1:0]  pterm_s3 [NUM_AXES];
	logic signed [PROD_W-1:0]  dterm_s3 [NUM_AXES];
	logic signed [PROD_W-1:0]  iprod_s3 [NUM_AXES];
	logic                      win_s3   [NUM_AXES];
	logic signed [INT_W-1:0]   integ_s4 [NUM_AXES];
	logic signed [ACC_W-1:0]   pd_s4    [NUM_AXES];
	logic signed [CORR_W-1:0]  corr_s5  [NUM_AXES];

	logic [MOTOR_W-1:0]        motor_q [4];
	logic signed [CORR_W-1:0]  corr_q  [NUM_AXES];

	logic [GAIN_W-1:0]         kp_a [NUM_AXES];
	logic [GAIN_W-1:0]         ki_a [NUM_AXES];
	logic [GAIN_W-1:0]         kd_a [NUM_AXES];
	logic signed [ERR_W-1:0]   err_c [NUM_AXES];
	logic                      win_c [NUM_AXES];
	logic signed [PROD_W-1:0]  pterm_c [NUM_AXES];
	logic signed [PROD_W-1:0]  dterm_c [NUM_AXES];
	logic signed [PROD_W-1:0]  iprod_c [NUM_AXES];
	logic signed [INT_W-1:0]   integ_c [NUM_AXES];
	logic signed [ACC_W-1:0]   pd_c    [NUM_AXES];
	logic signed [CORR_W-1:0]  corr_c  [NUM_AXES];
	logic [MOTOR_W-1:0]        motor_c [4];

	// ready chain
	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy_s5   = !v_s5 || rdy_out;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign in_ready = !v_s1 || rdy_s2;

	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			kp_a[k] = (k == AXIS_YAW) ? kp_yaw_q : kp_tilt_q;
			ki_a[k] = (k == AXIS_YAW) ? ki_yaw_q : ki_tilt_q;
			kd_a[k] = (k == AXIS_YAW) ? kd_yaw_q : kd_tilt_q;
		end
	end

	// stage 1 -> 2: error and window test
	always_comb begin
		logic signed [ERR_W-1:0] win_pos;
		logic signed [ERR_W-1:0] win_neg;
		win_pos = $signed(ERR_W'(window_q));
		win_neg = -win_pos;
		for (int k = 0; k < NUM_AXES; k++) begin
			err_c[k] = ERR_W'(tgt_s1[k]) - ERR_W'(meas_s1[k]);
			win_c[k] = (err_c[k] < win_pos) && (err_c[k] > win_neg);
		end
	end

	// stage 2 -> 3: products
	always_comb begin
		logic signed [PAIR_W-1:0] esum;
		logic signed [PAIR_W-1:0] ediff;
		for (int k = 0; k < NUM_AXES; k++) begin
			esum  = PAIR_W'(err_s2[k]) + PAIR_W'(prev_s2[k]);
			ediff = PAIR_W'(err_s2[k]) - PAIR_W'(prev_s2[k]);
			pterm_c[k] = PROD_W'($signed({1'b0, kp_a[k]})) * PROD_W'(err_s2[k]);
			dterm_c[k] = PROD_W'($signed({1'b0, kd_a[k]})) * PROD_W'(ediff);
			iprod_c[k] = PROD_W'($signed({1'b0, ki_a[k]})) * PROD_W'(esum);
		end
	end

	// stage 3 -> 4: integral update, P plus D sum
	always_comb begin
		logic [PROD_W-1:0]        rnd;
		logic signed [PROD_W-1:0] i_adj;
		logic signed [PROD_W-1:0] half;
		logic signed [ACC_W-1:0]  addend;
		logic signed [ACC_W-1:0]  acc;
		logic signed [ACC_W-1:0]  ilim_pos;
		logic signed [ACC_W-1:0]  ilim_neg;
		ilim_pos = $signed(ACC_W'({limit_q, {FRAC_W{1'b0}}}));
		ilim_neg = -ilim_pos;
		for (int k = 0; k < NUM_AXES; k++) begin
			rnd    = '0;
			rnd[0] = iprod_s3[k][PROD_W-1];
			i_adj  = iprod_s3[k] + $signed(rnd);
			half   = i_adj >>> 1;
			if (win_s3[k]) begin
				addend = ACC_W'(half);
			end else begin
				addend = '0;
			end
			acc = ACC_W'(integ_q[k]) + addend;
			if (acc > ilim_pos) begin
				integ_c[k] = ilim_pos[INT_W-1:0];
			end else if (acc < ilim_neg) begin
				integ_c[k] = ilim_neg[INT_W-1:0];
			end else begin
				integ_c[k] = acc[INT_W-1:0];
			end
			pd_c[k] = ACC_W'(pterm_s3[k]) + ACC_W'(dterm_s3[k]);
		end
	end

	// stage 4 -> 5: truncate toward zero, clamp
	always_comb begin
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-1:0] bias;
		logic signed [SUM_W-1:0] quo;
		logic signed [SUM_W-1:0] lim_pos;
		logic signed [SUM_W-1:0] lim_neg;
		lim_pos = $signed(SUM_W'(limit_q));
		lim_neg = -lim_pos;
		for (int k = 0; k < NUM_AXES; k++) begin
			sum  = SUM_W'(pd_s4[k]) + SUM_W'(integ_s4[k]);
			bias = '0;
			if (sum[SUM_W-1]) begin
				bias[FRAC_W-1:0] = '1;
			end
			quo = (sum + bias) >>> FRAC_W;
			if (quo > lim_pos) begin
				corr_c[k] = lim_pos[CORR_W-1:0];
			end else if (quo < lim_neg) begin
				corr_c[k] = lim_neg[CORR_W-1:0];
			end else begin
				corr_c[k] = quo[CORR_W-1:0];
			end
		end
	end

	// stage 5 -> out: X mixer
	always_comb begin
		logic signed [MIX_W-1:0] t;
		logic signed [MIX_W-1:0] r;
		logic signed [MIX_W-1:0] p;
		logic signed [MIX_W-1:0] y;
		t = $signed(MIX_W'(thr_s5));
		r = MIX_W'(corr_s5[AXIS_ROLL]);
		p = MIX_W'(corr_s5[AXIS_PITCH]);
		y = MIX_W'(corr_s5[AXIS_YAW]);
		motor_c[0] = clamp_motor(t + p + r + y);
		motor_c[1] = clamp_motor(t - p + r - y);
		motor_c[2] = clamp_motor(t + p - r - y);
		motor_c[3] = clamp_motor(t - p - r + y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_tilt_q   <= '0;
			ki_tilt_q   <= '0;
			kd_tilt_q   <= '0;
			kp_yaw_q    <= '0;
			ki_yaw_q    <= '0;
			kd_yaw_q    <= '0;
			window_q    <= WINDOW_RESET;
			limit_q     <= LIMIT_RESET;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NUM_AXES; k++) begin
				prev_q[k]  <= '0;
				integ_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_GAIN_P_TILT:      kp_tilt_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_I_TILT:      ki_tilt_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_D_TILT:      kd_tilt_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_P_YAW:       kp_yaw_q  <= cfg_data[GAIN_W-1:0];
					REG_GAIN_I_YAW:       ki_yaw_q  <= cfg_data[GAIN_W-1:0];
					REG_GAIN_D_YAW:       kd_yaw_q  <= cfg_data[GAIN_W-1:0];
					REG_INTEGRATE_WINDOW: window_q  <= cfg_data[WIN_W-1:0];
					REG_CORRECTION_LIMIT: limit_q   <= cfg_data[LIM_W-1:0];
					default:              limit_q   <= limit_q;
				endcase
			end
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
			if (rdy_out) begin
				out_valid_q <= v_s5;
			end
			// advance axis state as each item leaves its stage
			if (v_s1 && rdy_s2) begin
				for (int k = 0; k < NUM_AXES; k++) begin
					prev_q[k] <= err_c[k];
				end
			end
			if (v_s3 && rdy_s4) begin
				for (int k = 0; k < NUM_AXES; k++) begin
					integ_q[k] <= integ_c[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			thr_s1              <= throttle;
			meas_s1[AXIS_ROLL]  <= roll_angle;
			meas_s1[AXIS_PITCH] <= pitch_angle;
			meas_s1[AXIS_YAW]   <= yaw_rate;
			tgt_s1[AXIS_ROLL]   <= roll_target;
			tgt_s1[AXIS_PITCH]  <= pitch_target;
			tgt_s1[AXIS_YAW]    <= yaw_target;
		end
		if (v_s1 && rdy_s2) begin
			thr_s2 <= thr_s1;
			for (int k = 0; k < NUM_AXES; k++) begin
				err_s2[k]  <= err_c[k];
				prev_s2[k] <= prev_q[k];
				win_s2[k]  <= win_c[k];
			end
		end
		if (v_s2 && rdy_s3) begin
			thr_s3 <= thr_s2;
			for (int k = 0; k < NUM_AXES; k++) begin
				pterm_s3[k] <= pterm_c[k];
				dterm_s3[k] <= dterm_c[k];
				iprod_s3[k] <= iprod_c[k];
				win_s3[k]   <= win_s2[k];
			end
		end
		if (v_s3 && rdy_s4) begin
			thr_s4 <= thr_s3;
			for (int k = 0; k < NUM_AXES; k++) begin
				integ_s4[k] <= integ_c[k];
				pd_s4[k]    <= pd_c[k];
			end
		end
		if (v_s4 && rdy_s5) begin
			thr_s5 <= thr_s4;
			for (int k = 0; k < NUM_AXES; k++) begin
				corr_s5[k] <= corr_c[k];
			end
		end
		if (v_s5 && rdy_out) begin
			for (int m = 0; m < 4; m++) begin
				motor_q[m] <= motor_c[m];
			end
			for (int k = 0; k < NUM_AXES; k++) begin
				corr_q[k] <= corr_s5[k];
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign motor_front_a    = motor_q[0];
	assign motor_front_b    = motor_q[1];
	assign motor_rear_a     = motor_q[2];
	assign motor_rear_b     = motor_q[3];
	assign roll_correction  = corr_q[AXIS_ROLL];
	assign pitch_correction = corr_q[AXIS_PITCH];
	assign yaw_correction   = corr_q[AXIS_YAW];

endmodule

// File: rtl/apqm_checker.sv
`include "attitude_pid_with_quad_mixer_assert.svh"

module apqm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [apqm_pkg::MOTOR_W-1:0]        motor_front_a,
	input logic [apqm_pkg::MOTOR_W-1:0]        motor_front_b,
	input logic [apqm_pkg::MOTOR_W-1:0]        motor_rear_a,
	input logic [apqm_pkg::MOTOR_W-1:0]        motor_rear_b,
	input logic signed [apqm_pkg::CORR_W-1:0]  roll_correction,
	input logic signed [apqm_pkg::CORR_W-1:0]  pitch_correction,
	input logic signed [apqm_pkg::CORR_W-1:0]  yaw_correction
);
	import apqm_pkg::*;

	logic                           corr_zero;
	logic                           motors_equal;
	logic                           out_held;
	logic [4*MOTOR_W+3*CORR_W-1:0]  out_word;

	assign corr_zero    = roll_correction == 0 && pitch_correction == 0
		&& yaw_correction == 0;
	assign motors_equal = motor_front_a == motor_front_b && motor_front_a == motor_rear_a
		&& motor_front_a == motor_rear_b;
	assign out_held     = out_valid && !out_ready;
	assign out_word     = {motor_front_a, motor_front_b, motor_rear_a, motor_rear_b,
		roll_correction, pitch_correction, yaw_correction};

	`APQM_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_word), "held result changed")
	`APQM_ASSERT_RANGE(a_fa_range, out_valid, motor_front_a, MOTOR_MIN, MOTOR_MAX, "front_a range")
	`APQM_ASSERT_RANGE(a_rb_range, out_valid, motor_rear_b, MOTOR_MIN, MOTOR_MAX, "rear_b range")
	`APQM_ASSERT(a_level_mix, out_valid && corr_zero |-> motors_equal, "uneven motors, no correction")
	`APQM_ASSERT(a_empty_ready, !out_valid |-> in_ready, "input stalled with empty output")

endmodule

bind attitude_pid_with_quad_mixer apqm_checker u_apqm_checker (.*);
